@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the VCO lock sweep controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define VLSC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must be followed by an expression on the next clock edge.
`define VLSC_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

@@ src/vlsc_pkg.sv @@
// Types, constants and frame helpers of the VCO lock sweep controller.
`default_nettype none

package vlsc_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int BAND_STEPS  = 5;
	localparam int BIAS_TOP    = 15;

	localparam int SUM_BITS   = SAMPLE_BITS + 8;
	localparam int LEVEL_BITS = 19;
	localparam int CMP_BITS   = (SUM_BITS > LEVEL_BITS) ? SUM_BITS : LEVEL_BITS;

	localparam logic [9:0] SAMPLE_MASK = 10'((1 << SAMPLE_BITS) - 1);

	localparam logic [31:0] BAND_BASE_RESET = 32'd0;
	localparam logic [31:0] BIAS_BASE_RESET = 32'd0;
	localparam logic [9:0]  THRESH_RESET    = 10'd850;
	localparam logic [7:0]  SAMPLES_RESET   = 8'd100;
	localparam logic [LEVEL_BITS-1:0] LEVEL_RESET =
		LEVEL_BITS'((851) * 100);

	localparam logic [3:0] MUX_ANALOG_LOCK = 4'b0101;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef enum logic [1:0] {
		REG_BAND_BASE = 2'd0,
		REG_BIAS_BASE = 2'd1,
		REG_THRESHOLD = 2'd2,
		REG_SAMPLES   = 2'd3
	} reg_index_t;

	typedef enum logic {
		ACT_START  = 1'b0,
		ACT_SAMPLE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		KIND_FRAME  = 2'd0,
		KIND_LOCKED = 2'd1,
		KIND_FAILED = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_SWEEP  = 2'd1,
		PH_LOCKED = 2'd2,
		PH_FAILED = 2'd3
	} phase_t;

	typedef struct packed {
		logic       action;
		logic [9:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] frame;
		logic [2:0]  band_now;
		logic [3:0]  bias_now;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [1:0] n;
		out_item_t  first;
		out_item_t  second;
	} push_t;

	function automatic logic [31:0] make_frame0(input logic [31:0] base,
		input logic [2:0] band);
		logic [31:0] w;
		w = base;
		w[1:0] = 2'b00;
		w[24:23] = band[1:0];
		return w;
	endfunction

	function automatic logic [31:0] make_frame3(input logic [31:0] base,
		input logic [3:0] bias, input logic amp_on);
		logic [31:0] w;
		w = base;
		w[1:0] = 2'b11;
		w[2] = 1'b1;
		w[3] = amp_on;
		w[14:11] = MUX_ANALOG_LOCK;
		w[19:16] = bias;
		return w;
	endfunction

endpackage

`default_nettype wire

@@ src/vlsc_result_queue.sv @@
// Four-entry result queue taking up to two results per cycle and giving one per cycle unless stalled.
`default_nettype none

module vlsc_result_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  vlsc_pkg::push_t       push,
	output logic                  room,
	output logic                  result_valid,
	input  wire                   result_stall,
	output vlsc_pkg::out_item_t   result
);

	vlsc_pkg::out_item_t entry_q [vlsc_pkg::QUEUE_DEPTH];
	logic [vlsc_pkg::QPTR_W-1:0] wr_q;
	logic [vlsc_pkg::QPTR_W-1:0] rd_q;
	logic [vlsc_pkg::QCNT_W-1:0] cnt_q;
	logic pop;

	assign result_valid = (cnt_q != '0);
	assign result = entry_q[rd_q];
	assign pop = result_valid && !result_stall;
	assign room = (cnt_q <= vlsc_pkg::QCNT_W'(vlsc_pkg::QUEUE_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + vlsc_pkg::QPTR_W'(push.n);
			if (pop) begin
				rd_q <= rd_q + vlsc_pkg::QPTR_W'(1);
			end
			cnt_q <= cnt_q + vlsc_pkg::QCNT_W'(push.n) - vlsc_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			entry_q[wr_q] <= push.first;
		end
		if (push.n == 2'd2) begin
			entry_q[wr_q + vlsc_pkg::QPTR_W'(1)] <= push.second;
		end
	end

endmodule

`default_nettype wire

@@ src/vco_lock_sweep_controller_top.sv @@
// Top level of the VCO lock sweep controller: input register, sweep logic and result queue.
//
// The block steps a synthesizer's VCO band and bias settings, averaging a set
// number of lock-detect samples at each, and issues the control frames and a
// final locked or failed report. An item is registered on acceptance and
// processed once the result queue has room, which then takes its results.
// One item is taken every clock while the result queue has room; items
// that cause results are paced by the result queue, which delivers one
// result per cycle unless the output is stalled, so a start or end-of-try
// item gives one or two results. The average check compares the
// running sum with a registered product of threshold plus one and the sample
// count, so no divider is needed.
`default_nettype none
`include "assert_macros.svh"

module vco_lock_sweep_controller_top (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   item_valid,
	output logic                  item_stall,
	input  vlsc_pkg::in_item_t    item,
	output logic                  result_valid,
	input  wire                   result_stall,
	output vlsc_pkg::out_item_t   result,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire [1:0]             cfg_index,
	input  wire [31:0]            cfg_data
);

	logic [31:0] band_base_q;
	logic [31:0] bias_base_q;
	logic [9:0]  thresh_q;
	logic [7:0]  samples_q;
	logic [vlsc_pkg::LEVEL_BITS-1:0] level_q;

	logic                 valid_s1;
	vlsc_pkg::in_item_t   item_s1;

	vlsc_pkg::phase_t phase_q, phase_d;
	logic [2:0] band_q, band_d;
	logic [3:0] bias_q, bias_d;
	logic [7:0] tally_q, tally_d;
	logic [vlsc_pkg::SUM_BITS-1:0] sum_q, sum_d;

	logic [7:0]  count;
	logic [10:0] thresh_p1;
	logic [vlsc_pkg::LEVEL_BITS-1:0] level_d;
	logic [vlsc_pkg::SUM_BITS-1:0] sum_new;
	logic [7:0]  tally_new;
	logic        pass;
	logic        room;
	logic        proc;
	vlsc_pkg::push_t push;

	assign cfg_ready = 1'b1;
	assign proc = valid_s1 && room;
	assign item_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_base_q <= vlsc_pkg::BAND_BASE_RESET;
			bias_base_q <= vlsc_pkg::BIAS_BASE_RESET;
			thresh_q <= vlsc_pkg::THRESH_RESET;
			samples_q <= vlsc_pkg::SAMPLES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (vlsc_pkg::reg_index_t'(cfg_index))
				vlsc_pkg::REG_BAND_BASE: band_base_q <= cfg_data;
				vlsc_pkg::REG_BIAS_BASE: bias_base_q <= cfg_data;
				vlsc_pkg::REG_THRESHOLD: thresh_q <= cfg_data[9:0];
				vlsc_pkg::REG_SAMPLES: samples_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign count = (samples_q == 8'd0) ? 8'd1 : samples_q;
	assign thresh_p1 = {1'b0, thresh_q} + 11'd1;
	assign level_d = vlsc_pkg::LEVEL_BITS'(thresh_p1) * vlsc_pkg::LEVEL_BITS'(count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= vlsc_pkg::LEVEL_RESET;
		end else begin
			level_q <= level_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (item_valid && !item_stall) || (valid_s1 && !proc);
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= vlsc_pkg::PH_IDLE;
			band_q <= 3'd0;
			bias_q <= 4'd1;
			tally_q <= 8'd0;
			sum_q <= '0;
		end else begin
			phase_q <= phase_d;
			band_q <= band_d;
			bias_q <= bias_d;
			tally_q <= tally_d;
			sum_q <= sum_d;
		end
	end

	assign sum_new = sum_q
		+ vlsc_pkg::SUM_BITS'(item_s1.sample & vlsc_pkg::SAMPLE_MASK);
	assign tally_new = tally_q + 8'd1;
	assign pass = (vlsc_pkg::CMP_BITS'(sum_new) >= vlsc_pkg::CMP_BITS'(level_q));

	always_comb begin
		phase_d = phase_q;
		band_d = band_q;
		bias_d = bias_q;
		tally_d = tally_q;
		sum_d = sum_q;
		push = '0;
		if (proc) begin
			if (item_s1.action == vlsc_pkg::ACT_START) begin
				phase_d = vlsc_pkg::PH_SWEEP;
				band_d = 3'd0;
				bias_d = 4'd1;
				tally_d = 8'd0;
				sum_d = '0;
				push.n = 2'd2;
			end else if (phase_q == vlsc_pkg::PH_SWEEP) begin
				if (tally_new < count) begin
					tally_d = tally_new;
					sum_d = sum_new;
				end else begin
					tally_d = 8'd0;
					sum_d = '0;
					if (pass) begin
						phase_d = vlsc_pkg::PH_LOCKED;
						push.n = 2'd2;
					end else if (bias_q >= 4'(vlsc_pkg::BIAS_TOP)) begin
						if ({1'b0, band_q} + 4'd1 >= 4'(vlsc_pkg::BAND_STEPS)) begin
							phase_d = vlsc_pkg::PH_FAILED;
							push.n = 2'd1;
						end else begin
							band_d = band_q + 3'd1;
							bias_d = 4'd1;
							push.n = 2'd2;
						end
					end else begin
						bias_d = bias_q + 4'd1;
						push.n = 2'd2;
					end
				end
			end
		end

		push.first.band_now = band_d;
		push.first.bias_now = bias_d;
		push.second.band_now = band_d;
		push.second.bias_now = bias_d;
		case (phase_d)
			vlsc_pkg::PH_LOCKED: begin
				push.first.kind = vlsc_pkg::KIND_FRAME;
				push.first.frame = vlsc_pkg::make_frame3(bias_base_q, bias_d, 1'b1);
				push.first.last = 1'b0;
				push.second.kind = vlsc_pkg::KIND_LOCKED;
				push.second.frame = 32'd0;
				push.second.last = 1'b1;
			end
			vlsc_pkg::PH_FAILED: begin
				push.first.kind = vlsc_pkg::KIND_FAILED;
				push.first.frame = 32'd0;
				push.first.last = 1'b1;
				push.second.kind = vlsc_pkg::KIND_FAILED;
				push.second.frame = 32'd0;
				push.second.last = 1'b1;
			end
			default: begin
				push.first.kind = vlsc_pkg::KIND_FRAME;
				push.first.frame = vlsc_pkg::make_frame0(band_base_q, band_d);
				push.first.last = 1'b0;
				push.second.kind = vlsc_pkg::KIND_FRAME;
				push.second.frame = vlsc_pkg::make_frame3(bias_base_q, bias_d, 1'b0);
				push.second.last = 1'b1;
			end
		endcase
	end

	vlsc_result_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	`VLSC_ASSERT(a_idle_setting, (phase_q != vlsc_pkg::PH_IDLE) || (band_q == 3'd0 && bias_q == 4'd1 && tally_q == 8'd0 && sum_q == '0), "Idle phase holds a non-initial sweep setting.")
	`VLSC_ASSERT(a_bias_range, bias_q >= 4'd1 && bias_q <= 4'(vlsc_pkg::BIAS_TOP), "Bias step left its range.")
	`VLSC_ASSERT_NEXT(a_start_clears, proc && item_s1.action == vlsc_pkg::ACT_START, phase_q == vlsc_pkg::PH_SWEEP && tally_q == 8'd0 && sum_q == '0, "Start did not restart the sweep.")
	`VLSC_ASSERT_NEXT(a_ignored_sample, proc && item_s1.action == vlsc_pkg::ACT_SAMPLE && phase_q != vlsc_pkg::PH_SWEEP, $stable(sum_q) && $stable(phase_q), "Sample outside a sweep changed the state.")

endmodule

`default_nettype wire
